// ----- rtl/core/msae_pkg.sv -----
// Package for the MIPS64 SPECIAL-group execute block.
// Holds payload structs and function codes; no dependencies.
package msae_pkg;

    typedef struct packed {
        logic [5:0]  operation;
        logic [63:0] source_value;
        logic [63:0] target_value;
        logic [4:0]  shift_amount;
    } t_in_word;

    typedef struct packed {
        logic [63:0] dest_value;
        logic        dest_write;
        logic        unsupported;
    } t_out_word;

    localparam logic [5:0] OP_SLL    = 6'h00;
    localparam logic [5:0] OP_SRL    = 6'h02;
    localparam logic [5:0] OP_SRA    = 6'h03;
    localparam logic [5:0] OP_SLLV   = 6'h04;
    localparam logic [5:0] OP_SRLV   = 6'h06;
    localparam logic [5:0] OP_SRAV   = 6'h07;
    localparam logic [5:0] OP_JR     = 6'h08;
    localparam logic [5:0] OP_SYNC   = 6'h0F;
    localparam logic [5:0] OP_MFHI   = 6'h10;
    localparam logic [5:0] OP_MTHI   = 6'h11;
    localparam logic [5:0] OP_MFLO   = 6'h12;
    localparam logic [5:0] OP_MTLO   = 6'h13;
    localparam logic [5:0] OP_MULT   = 6'h18;
    localparam logic [5:0] OP_MULTU  = 6'h19;
    localparam logic [5:0] OP_DIV    = 6'h1A;
    localparam logic [5:0] OP_DIVU   = 6'h1B;
    localparam logic [5:0] OP_DMULT  = 6'h1C;
    localparam logic [5:0] OP_DMULTU = 6'h1D;
    localparam logic [5:0] OP_DDIV   = 6'h1E;
    localparam logic [5:0] OP_DDIVU  = 6'h1F;
    localparam logic [5:0] OP_ADD    = 6'h20;
    localparam logic [5:0] OP_ADDU   = 6'h21;
    localparam logic [5:0] OP_SUB    = 6'h22;
    localparam logic [5:0] OP_SUBU   = 6'h23;
    localparam logic [5:0] OP_AND    = 6'h24;
    localparam logic [5:0] OP_OR     = 6'h25;
    localparam logic [5:0] OP_XOR    = 6'h26;
    localparam logic [5:0] OP_NOR    = 6'h27;
    localparam logic [5:0] OP_SLT    = 6'h2A;
    localparam logic [5:0] OP_SLTU   = 6'h2B;
    localparam logic [5:0] OP_DADD   = 6'h2C;
    localparam logic [5:0] OP_DADDU  = 6'h2D;
    localparam logic [5:0] OP_DSUB   = 6'h2E;
    localparam logic [5:0] OP_DSUBU  = 6'h2F;
    localparam logic [5:0] OP_DSLL32 = 6'h3C;
    localparam logic [5:0] OP_DSRL32 = 6'h3E;
    localparam logic [5:0] OP_DSRA32 = 6'h3F;

    localparam int unsigned MD_STEPS = 64;

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

// ----- rtl/core/msae_muldiv.sv -----
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// Depends on msae_pkg. Works on unsigned magnitudes; sign fixes are outside.
module msae_muldiv
    import msae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_div,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_hi,
    output logic [63:0] o_lo
);

    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_div;
    logic [63:0] r_b;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [64:0] w_sum;
    logic [64:0] w_rem;
    logic [64:0] w_diff;

    // Multiply: conditional add of b into hi, then shift hi:lo right.
    // Divide: shift remainder:quotient left, trial subtract.
    assign w_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : 65'd0);
    assign w_rem  = {r_hi, r_lo[63]};
    assign w_diff = w_rem - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(MD_STEPS);
                r_div  <= i_div;
                r_b    <= i_b;
                r_hi   <= '0;
                r_lo   <= i_a;
            end else if (r_busy) begin
                if (r_div) begin
                    if (!w_diff[64]) begin
                        r_hi <= w_diff[63:0];
                        r_lo <= {r_lo[62:0], 1'b1};
                    end else begin
                        r_hi <= w_rem[63:0];
                        r_lo <= {r_lo[62:0], 1'b0};
                    end
                end else begin
                    r_hi <= w_sum[64:1];
                    r_lo <= {w_sum[0], r_lo[63:1]};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;

endmodule

// ----- rtl/core/mips64_special_alu_execute.sv -----
// Top level of the MIPS64 SPECIAL-group execute block with HI/LO.
// Depends on msae_pkg and msae_muldiv.
//
//  channel | signals                     | payload
//  in      | i_in_valid / o_in_ready     | t_in_word  i_in_word
//  out     | o_out_valid / i_out_ready   | t_out_word o_out_word
//
// ALU, shift and move words have their result valid in the cycle after acceptance.
// Multiply and divide take 64 steps in the shared bit-serial unit; its done flag
// moves the sequencer to the sign fix-up state, which writes HI/LO and raises valid.
// Synchronous active-low reset clears HI, LO and the sequencer.
// One word at a time: input is not ready until the result is taken.
module mips64_special_alu_execute
    import msae_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef enum logic [1:0] {S_IDLE, S_MD, S_FIX, S_OUT} t_state;

    t_state      r_state;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [5:0]  r_op;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_zero;
    logic        r_ovf;
    logic [63:0] r_dvd;

    logic        w_start;
    logic        w_div;
    logic [63:0] w_a;
    logic [63:0] w_b;
    logic        w_done;
    logic [63:0] w_mhi;
    logic [63:0] w_mlo;

    logic [63:0] rs;
    logic [63:0] rt;
    logic [4:0]  sa;
    logic [4:0]  w_amt;
    logic [63:0] n_val;
    logic        n_wr;
    logic        n_bad;
    logic        w_md;
    logic        w_accept;
    logic [63:0] w_sa;
    logic [63:0] w_sb;
    logic [63:0] w_ma;
    logic [63:0] w_mb;
    logic        w_na;
    logic        w_nb;
    logic [63:0] w_q;
    logic [63:0] w_r;
    logic [63:0] n_hi;
    logic [63:0] n_lo;

    assign rs = i_in_word.source_value;
    assign rt = i_in_word.target_value;
    assign sa = i_in_word.shift_amount;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_amt = (i_in_word.operation[2]) ? rs[4:0] : sa;

    always_comb begin
        n_val = '0;
        n_wr  = 1'b1;
        n_bad = 1'b0;
        w_md  = 1'b0;
        unique case (i_in_word.operation)
            OP_SLL, OP_SLLV: n_val = sx32(rt[31:0] << w_amt);
            OP_SRL, OP_SRLV: n_val = sx32(rt[31:0] >> w_amt);
            OP_SRA, OP_SRAV: n_val = sx32(32'($signed(rt[31:0]) >>> w_amt));
            OP_SYNC, OP_MTHI, OP_MTLO: n_wr = 1'b0;
            OP_MFHI: n_val = r_hi;
            OP_MFLO: n_val = r_lo;
            OP_MULT, OP_MULTU, OP_DIV, OP_DIVU,
            OP_DMULT, OP_DMULTU, OP_DDIV, OP_DDIVU: begin
                n_wr = 1'b0;
                w_md = 1'b1;
            end
            OP_ADD, OP_ADDU: n_val = sx32(rs[31:0] + rt[31:0]);
            OP_SUB, OP_SUBU: n_val = sx32(rs[31:0] - rt[31:0]);
            OP_AND: n_val = rs & rt;
            OP_OR:  n_val = rs | rt;
            OP_XOR: n_val = rs ^ rt;
            OP_NOR: n_val = ~(rs | rt);
            OP_SLT: n_val = {63'd0, $signed(rs) < $signed(rt)};
            OP_SLTU: n_val = {63'd0, rs < rt};
            OP_DADD, OP_DADDU: n_val = rs + rt;
            OP_DSUB, OP_DSUBU: n_val = rs - rt;
            OP_DSLL32: n_val = {rt[31:0], 32'd0} << sa;
            OP_DSRL32: n_val = {32'd0, rt[63:32]} >> sa;
            OP_DSRA32: n_val = 64'($signed({{32{rt[63]}}, rt[63:32]}) >>> sa);
            default: begin
                n_wr  = 1'b0;
                n_bad = 1'b1;
            end
        endcase
    end

    // Operands for the shared unit: word ops take sign or zero extension,
    // signed ops are turned into magnitudes.
    always_comb begin
        w_sa = rs;
        w_sb = rt;
        w_na = 1'b0;
        w_nb = 1'b0;
        case (i_in_word.operation)
            OP_MULT, OP_DIV: begin
                w_sa = sx32(rs[31:0]);
                w_sb = sx32(rt[31:0]);
                w_na = rs[31];
                w_nb = rt[31];
            end
            OP_MULTU, OP_DIVU: begin
                w_sa = {32'd0, rs[31:0]};
                w_sb = {32'd0, rt[31:0]};
            end
            OP_DMULT, OP_DDIV: begin
                w_na = rs[63];
                w_nb = rt[63];
            end
            default: ;
        endcase
        w_ma = w_na ? -w_sa : w_sa;
        w_mb = w_nb ? -w_sb : w_sb;
    end

    assign w_start = w_accept && w_md;
    assign w_div   = i_in_word.operation[1];
    assign w_a     = w_ma;
    assign w_b     = w_mb;

    msae_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_div  (w_div),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_done (w_done),
        .o_hi   (w_mhi),
        .o_lo   (w_mlo)
    );

    // Sign fix-up of the unit's magnitude result.
    always_comb begin
        w_q = r_neg_q ? -w_mlo : w_mlo;
        w_r = r_neg_r ? -w_mhi : w_mhi;
        n_hi = r_hi;
        n_lo = r_lo;
        if (!r_op[1]) begin
            // 128-bit product negation for the signed forms.
            {n_hi, n_lo} = r_neg_q ? -{w_mhi, w_mlo} : {w_mhi, w_mlo};
            if (!r_op[2]) begin
                // A word product fits in 64 bits; split it into two sign-extended halves.
                n_lo = sx32(w_q[31:0]);
                n_hi = sx32(w_q[63:32]);
            end
        end else if (!r_zero) begin
            if (r_ovf) begin
                n_lo = r_dvd;
                n_hi = '0;
            end else if (!r_op[2]) begin
                n_lo = sx32(w_q[31:0]);
                n_hi = sx32(w_r[31:0]);
            end else begin
                n_lo = w_q;
                n_hi = w_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hi        <= '0;
            r_lo        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_in_word.operation;
                        r_neg_q <= w_na ^ w_nb;
                        r_neg_r <= w_na;
                        r_zero  <= (w_sb == 64'd0);
                        r_ovf   <= w_na && (w_sa == {1'b1, 63'd0}) && (w_sb == '1);
                        r_dvd   <= w_sa;
                        o_out_word.dest_value  <= n_val;
                        o_out_word.dest_write  <= n_wr;
                        o_out_word.unsupported <= n_bad;
                        if (i_in_word.operation == OP_MTHI) r_hi <= rs;
                        if (i_in_word.operation == OP_MTLO) r_lo <= rs;
                        if (w_md) begin
                            r_state <= S_MD;
                        end else begin
                            r_state     <= S_OUT;
                            o_out_valid <= 1'b1;
                        end
                    end
                end
                S_MD: begin
                    if (w_done) r_state <= S_FIX;
                end
                S_FIX: begin
                    r_hi        <= n_hi;
                    r_lo        <= n_lo;
                    r_state     <= S_OUT;
                    o_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MD) |=> (r_hi == $past(r_hi)) && (r_lo == $past(r_lo)))
        else $error("HI/LO changed during multiply or divide");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.unsupported) |-> !o_out_word.dest_write)
        else $error("unsupported word flagged as a write");

endmodule
